// ===== hw/rtl/qsh_pkg.sv =====
// Package: request/result types, hash constants and per-byte hash functions.
`timescale 1ns / 1ps
`default_nettype none

package qsh_pkg;

  localparam int unsigned QSH_QUEUE_DEPTH = 2;

  localparam logic [31:0] QSH_DJB_SEED = 32'd0;
  localparam logic [31:0] QSH_FNV_SEED = 32'd2166136261;
  localparam logic [31:0] QSH_OAT_SEED = 32'd0;
  localparam logic [31:0] QSH_SAX_SEED = 32'd0;
  localparam logic [31:0] QSH_FNV_PRIME = 32'd16777619;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [31:0] djb_hash;
    logic [31:0] fnv_hash;
    logic [31:0] oat_hash;
    logic [31:0] sax_hash;
  } out_res_t;

  // Queue write side: front to queue.
  typedef struct packed {
    logic    valid;
    in_req_t req;
  } q_push_t;

  // Queue read side: queue to back.
  typedef struct packed {
    logic    valid;
    in_req_t req;
  } q_head_t;

  function automatic logic [31:0] djb_fold(input logic [31:0] h, input logic [7:0] b);
    djb_fold = (h << 5) + h + {24'd0, b};
  endfunction

  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] p;
    p = h * QSH_FNV_PRIME;
    fnv_fold = p ^ {24'd0, b};
  endfunction

  function automatic logic [31:0] oat_fold(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    oat_fold = t;
  endfunction

  function automatic logic [31:0] sax_fold(input logic [31:0] h, input logic [7:0] b);
    sax_fold = h ^ ((h << 5) + (h >> 2) + {24'd0, b});
  endfunction

  function automatic logic [31:0] oat_finish(input logic [31:0] h);
    logic [31:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    oat_finish = t;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qsh_front.sv =====
// Front end: accept input requests and drop those that carry no work.
`timescale 1ns / 1ps
`default_nettype none

module qsh_front import qsh_pkg::*; (
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire in_req_t in_data,
  input  wire logic    q_full,
  output q_push_t      push
);

  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Drop an empty non-last request: it changes nothing.
  always_comb begin
    push.valid = accept && (in_data.byte_present || in_data.last);
    push.req   = in_data;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qsh_queue.sv =====
// Short request queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module qsh_queue import qsh_pkg::*; #(
  parameter int unsigned DEPTH = QSH_QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_push_t push,
  output logic         q_full,
  output q_head_t      head,
  input  wire logic    pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  in_req_t       mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_full     = (cnt_r == FULL_CNT);
  assign do_push    = push.valid && !q_full;
  assign head.valid = (cnt_r != '0);
  assign head.req   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.req;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qsh_back.sv =====
// Back end: fold bytes into the four hashes and hold the finished result.
`timescale 1ns / 1ps
`default_nettype none

module qsh_back import qsh_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_head_t head,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_res_t     out_data
);

  logic [31:0] djb_r, djb_nxt;
  logic [31:0] fnv_r, fnv_nxt;
  logic [31:0] oat_r, oat_nxt;
  logic [31:0] sax_r, sax_nxt;
  logic [31:0] djb_f, fnv_f, oat_f, sax_f;
  out_res_t    res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;
  // Hold a last request until the result register can take it.
  assign pop      = head.valid && (!head.req.last || out_free);

  always_comb begin
    djb_f = djb_r;
    fnv_f = fnv_r;
    oat_f = oat_r;
    sax_f = sax_r;
    if (head.req.byte_present) begin
      djb_f = djb_fold(djb_r, head.req.data_byte);
      fnv_f = fnv_fold(fnv_r, head.req.data_byte);
      oat_f = oat_fold(oat_r, head.req.data_byte);
      sax_f = sax_fold(sax_r, head.req.data_byte);
    end
  end

  always_comb begin
    djb_nxt       = djb_r;
    fnv_nxt       = fnv_r;
    oat_nxt       = oat_r;
    sax_nxt       = sax_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop) begin
      djb_nxt = djb_f;
      fnv_nxt = fnv_f;
      oat_nxt = oat_f;
      sax_nxt = sax_f;
      if (head.req.last) begin
        res_nxt.djb_hash = djb_f;
        res_nxt.fnv_hash = fnv_f;
        res_nxt.oat_hash = oat_f;
        res_nxt.sax_hash = sax_f;
        out_valid_nxt    = 1'b1;
        djb_nxt          = QSH_DJB_SEED;
        fnv_nxt          = QSH_FNV_SEED;
        oat_nxt          = QSH_OAT_SEED;
        sax_nxt          = QSH_SAX_SEED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      djb_r       <= QSH_DJB_SEED;
      fnv_r       <= QSH_FNV_SEED;
      oat_r       <= QSH_OAT_SEED;
      sax_r       <= QSH_SAX_SEED;
      out_valid_r <= 1'b0;
    end else begin
      djb_r       <= djb_nxt;
      fnv_r       <= fnv_nxt;
      oat_r       <= oat_nxt;
      sax_r       <= sax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Finalize one-at-a-time off the held register; stable while stalled.
  always_comb begin
    out_data          = res_r;
    out_data.oat_hash = oat_finish(res_r.oat_hash);
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/quad_string_hash.sv =====
// Top level: four running 32-bit string hashes over a byte stream.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake           Payload
// in_      in   in_valid/in_stall   in_req_t   {data_byte, byte_present, last}
// out_     out  out_valid/out_stall out_res_t  {djb, fnv, oat, sax hashes}
//
// One request per cycle is taken sustained while the queue is not full; each
// byte passes front end, queue and back-end fold: the queue registers a last
// request, then the result register takes its hashes. All four hashes update
// together; the FNV constant multiply is the deepest path.
// Reset (rst_n low, synchronous) empties the queue, clears out_valid and loads
// the seed values into the hashes.
// out_stall holds the result; a last request waits in the queue, and in_stall
// rises once the queue is full.

module quad_string_hash import qsh_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QSH_QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_res_t      out_data
);

  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  // Accept requests and drop the empty ones that are not last.
  qsh_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push)
  );

  // Decouple the front end from back-end stalls.
  qsh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .head   (head),
    .pop    (pop)
  );

  // Fold bytes, finish on last, hold the result for the consumer.
  qsh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
